// ===== hdl/gqg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gqg_pkg;
  localparam int unsigned Population = 8;
  localparam int unsigned Genes = 8;

  typedef logic signed [10:0] energy_t;

  typedef enum logic [1:0] {
    StatusEvolved   = 2'd0,
    StatusConverged = 2'd1,
    StatusLimit     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CfgInitPop   = 2'd0,
    CfgMaxGen    = 2'd1,
    CfgXoverThr  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle, StCount, StDecide, StEnergy, StFitness, StSelect, StMult, StCommit, StCross,
    StDone
  } state_e;

  function automatic logic signed [4:0] wmat(input logic [2:0] i, input logic [2:0] j);
    logic signed [4:0] t [64];
    t = '{ 5'sd4, -5'sd3, 5'sd2, 5'sd7, 5'sd5, -5'sd1, 5'sd0, 5'sd2,
          -5'sd3, 5'sd8, -5'sd5, 5'sd1, 5'sd0, -5'sd2, 5'sd3, -5'sd4,
           5'sd2, -5'sd5, 5'sd7, -5'sd6, 5'sd1, 5'sd3, -5'sd4, 5'sd5,
           5'sd7, 5'sd1, -5'sd6, 5'sd9, 5'sd3, -5'sd2, 5'sd2, -5'sd3,
           5'sd5, 5'sd0, 5'sd1, 5'sd3, -5'sd10, -5'sd4, 5'sd3, -5'sd2,
          -5'sd1, -5'sd2, 5'sd3, -5'sd2, -5'sd4, 5'sd8, 5'sd1, -5'sd1,
           5'sd0, 5'sd3, -5'sd4, 5'sd2, 5'sd3, 5'sd1, 5'sd7, -5'sd6,
           5'sd2, -5'sd4, 5'sd5, -5'sd3, -5'sd2, -5'sd1, -5'sd6, 5'sd9 };
    return t[{i, j}];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/gqg_energy.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gqg_energy import gqg_pkg::*; (
  input  wire logic [7:0] chrom_i,
  input  wire logic [2:0] row_i,
  output energy_t         energy_o
);
  // one row of the quadratic form; rows summed over cycles by the sequencer
  always_comb begin
    energy_o = '0;
    if (chrom_i[3'd7 - row_i]) begin
      for (int j = 0; j < Genes; j++) begin
        if (chrom_i[7-j]) begin
          energy_o = energy_o + energy_t'(wmat(row_i, 3'(j)));
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/genetic_qubo_generation.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | valid       | ready       | payload
// cfg      | cfg_valid_i | cfg_ready_o | cfg_index_i, cfg_data_i
// in       | in_valid_i  | in_ready_o  | restart_i, draws, points, mask
// out      | out_valid_o | out_ready_i | status_o, solution_o, generation_o, population_out_o
// The count pass compares every member pair, one member compare each, then a decide step;
// converged or limited requests then present the result.
// Evolving requests add an energy pass (one matrix row each), a fitness pass over the
// members, roulette selection set by where each draw lands (one 16x14 multiply, then one
// compare per member scanned), one commit and a crossover pass over the four pairs.
// in_ready_o is low from acceptance until the result is taken.
// Reset clears population, generation count and seed; max gen resets to 300, threshold to 49151.
module genetic_qubo_generation import gqg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        restart_i,
  input  wire logic [63:0] select_draws_low_i,
  input  wire logic [63:0] select_draws_high_i,
  input  wire logic [63:0] crossover_draws_i,
  input  wire logic [11:0] crossover_points_i,
  input  wire logic [63:0] mutation_mask_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [7:0]       solution_o,
  output logic [15:0]      generation_o,
  output logic [63:0]      population_out_o
);
  state_e state_q, state_d;
  logic [63:0] init_q;
  logic [15:0] maxg_q, thr_q, gen_q;
  logic [7:0] pop_q [8];
  logic [7:0] nxt_q [8];
  logic [127:0] draws_q;
  logic [63:0] xd_q, mask_q;
  logic [11:0] pts_q;
  logic [2:0] i_q, j_q;
  logic [3:0] cnt_q, best_cnt_q;
  logic [7:0] sol_q;
  energy_t e_q [8];
  energy_t maxe_q, acc_q;
  logic [13:0] cum_q [8];
  logic [13:0] total_q;
  logic [29:0] lhs_q;
  logic [1:0] status_q;
  energy_t e_w, esum_w;
  logic [3:0] cnt_w;
  logic [13:0] fit_w;
  logic hit_w;
  logic [7:0] xa_w, xb_w, xm_w, ca_w, cb_w;

  gqg_energy u_energy (.chrom_i(pop_q[i_q]), .row_i(j_q), .energy_o(e_w));

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StDone);
  assign status_o = status_q;
  assign solution_o = sol_q;
  assign generation_o = gen_q;
  always_comb begin
    for (int k = 0; k < Population; k++) population_out_o[63-8*k -: 8] = pop_q[k];
  end

  assign esum_w = acc_q + e_w;
  assign cnt_w = cnt_q + ((pop_q[i_q] == pop_q[j_q]) ? 4'd1 : 4'd0);
  assign fit_w = total_q + 14'(maxe_q - e_q[i_q] + energy_t'(1));
  assign hit_w = (j_q == 3'd7) || (lhs_q <= 30'(cum_q[j_q]) * 30'd65535);

  // pair i_q[1:0] of the crossover pass
  always_comb begin
    xa_w = pop_q[{i_q[1:0], 1'b0}];
    xb_w = pop_q[{i_q[1:0], 1'b1}];
    xm_w = 8'hff >> pts_q[11:9];
    if (xd_q[63:48] <= thr_q) begin
      ca_w = (xa_w & ~xm_w) | (xb_w & xm_w);
      cb_w = (xb_w & ~xm_w) | (xa_w & xm_w);
    end else begin
      ca_w = xa_w;
      cb_w = xb_w;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:    if (in_valid_i) state_d = StCount;
      StCount:   if (i_q == 3'd7 && j_q == 3'd7) state_d = StDecide;
      StDecide:  state_d = (best_cnt_q >= 4'd6 || gen_q >= maxg_q) ? StDone : StEnergy;
      StEnergy:  if (i_q == 3'd7 && j_q == 3'd7) state_d = StFitness;
      StFitness: if (i_q == 3'd7) state_d = StMult;
      StMult:    state_d = StSelect;
      StSelect:  if (hit_w) begin
                   state_d = (i_q == 3'd7) ? StCommit : StMult;
                 end
      StCommit:  state_d = StCross;
      StCross:   if (i_q == 3'd3) state_d = StDone;
      StDone:    if (out_ready_i) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      init_q <= '0;
      maxg_q <= 16'd300;
      thr_q <= 16'd49151;
      gen_q <= '0;
      for (int k = 0; k < Population; k++) pop_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgInitPop:  init_q <= cfg_data_i;
          CfgMaxGen:   maxg_q <= cfg_data_i[15:0];
          CfgXoverThr: thr_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == StIdle && in_valid_i && restart_i) begin
        for (int k = 0; k < Population; k++) pop_q[k] <= init_q[63-8*k -: 8];
        gen_q <= '0;
      end
      if (state_q == StCommit) begin
        for (int k = 0; k < Population; k++) pop_q[k] <= nxt_q[k];
      end
      if (state_q == StCross) begin
        pop_q[{i_q[1:0], 1'b0}] <= ca_w ^ mask_q[63:56];
        pop_q[{i_q[1:0], 1'b1}] <= cb_w ^ mask_q[55:48];
        if (i_q == 3'd3) gen_q <= gen_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        draws_q <= {select_draws_low_i, select_draws_high_i};
        xd_q <= crossover_draws_i;
        pts_q <= crossover_points_i;
        mask_q <= mutation_mask_i;
        i_q <= '0;
        j_q <= '0;
        cnt_q <= '0;
        best_cnt_q <= '0;
        maxe_q <= '0;
        acc_q <= '0;
        total_q <= '0;
        status_q <= StatusEvolved;
        sol_q <= '0;
      end
      StCount: begin
        j_q <= j_q + 3'd1;
        if (j_q == 3'd7) begin
          cnt_q <= '0;
          i_q <= i_q + 3'd1;
          if (cnt_w > best_cnt_q) begin
            best_cnt_q <= cnt_w;
            sol_q <= pop_q[i_q];
          end
        end else begin
          cnt_q <= cnt_w;
        end
      end
      StDecide: begin
        status_q <= (best_cnt_q >= 4'd6) ? StatusConverged :
                    (gen_q >= maxg_q) ? StatusLimit : StatusEvolved;
        i_q <= '0;
        j_q <= '0;
        acc_q <= '0;
      end
      StEnergy: begin
        if (j_q == 3'd7) begin
          e_q[i_q] <= esum_w;
          if (esum_w > maxe_q) maxe_q <= esum_w;
          acc_q <= '0;
          i_q <= i_q + 3'd1;
        end else begin
          acc_q <= esum_w;
        end
        j_q <= j_q + 3'd1;
      end
      StFitness: begin
        total_q <= fit_w;
        cum_q[i_q] <= fit_w;
        i_q <= i_q + 3'd1;
        j_q <= '0;
      end
      StMult: begin
        lhs_q <= 30'(draws_q[127:112]) * 30'(total_q);
        j_q <= '0;
      end
      StSelect: begin
        if (hit_w) begin
          nxt_q[i_q] <= pop_q[j_q];
          i_q <= i_q + 3'd1;
          draws_q <= draws_q << 16;
        end else begin
          j_q <= j_q + 3'd1;
        end
      end
      StCross: begin
        i_q <= i_q + 3'd1;
        xd_q <= xd_q << 16;
        pts_q <= pts_q << 3;
        mask_q <= mask_q << 16;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready during result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StatusEvolved) |-> $stable(generation_o) || $past(in_ready_o))
    else $error("generation moved");
`endif
endmodule
`default_nettype wire

// ===== sim/genetic_qubo_generation_tb.sv =====
`timescale 1ns / 1ps
module genetic_qubo_generation_tb;
  import gqg_pkg::*;

  localparam int WGT [64] = '{
     4, -3,  2,  7,   5, -1,  0,  2,
    -3,  8, -5,  1,   0, -2,  3, -4,
     2, -5,  7, -6,   1,  3, -4,  5,
     7,  1, -6,  9,   3, -2,  2, -3,
     5,  0,  1,  3, -10, -4,  3, -2,
    -1, -2,  3, -2,  -4,  8,  1, -1,
     0,  3, -4,  2,   3,  1,  7, -6,
     2, -4,  5, -3,  -2, -1, -6,  9};

  typedef struct packed {
    status_e     status;
    logic [7:0]  solution;
    logic [15:0] generation;
    logic [63:0] pop;
  } gen_result_t;

  typedef struct {
    logic        restart;
    logic [63:0] sel_lo;
    logic [63:0] sel_hi;
    logic [63:0] xo_draws;
    logic [11:0] xo_points;
    logic [63:0] mut_mask;
    bit          typed;
    gen_result_t want;
  } gen_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        restart_i;
  logic [63:0] select_draws_low_i;
  logic [63:0] select_draws_high_i;
  logic [63:0] crossover_draws_i;
  logic [11:0] crossover_points_i;
  logic [63:0] mutation_mask_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [7:0]  solution_o;
  logic [15:0] generation_o;
  logic [63:0] population_out_o;

  genetic_qubo_generation uut (.*);

  // predictor state
  logic [7:0]  members [8];
  logic [15:0] gen_count;
  logic [63:0] seed_pop;
  logic [15:0] gen_limit;
  logic [15:0] xo_thresh;

  gen_result_t pending_q [$];
  bit          failed;
  bit          calm;
  gen_row_t    rows [10];

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = 1'b1;
      #5 clk_i = 1'b0;
    end
  end

  initial begin
    #20ms;
    $display("genetic_qubo_generation regression: fail");
    $finish;
  end

  function automatic longint qubo_energy(input logic [7:0] c);
    longint e;
    e = 0;
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++)
        if (c[7-i] && c[7-j]) e += WGT[i*8+j];
    return e;
  endfunction

  task automatic predict_generation(input gen_row_t r, output gen_result_t res);
    longint e [8];
    longint cum [8];
    longint maxe, total, d;
    logic [7:0] nxt [8];
    logic [7:0] a, b, m;
    logic [63:0] w;
    int cnt, best, bestcnt, pick;
    if (r.restart) begin
      for (int i = 0; i < 8; i++) members[i] = seed_pop[63-8*i -: 8];
      gen_count = '0;
    end
    best = 0;
    bestcnt = 0;
    for (int i = 0; i < 8; i++) begin
      cnt = 0;
      for (int k = 0; k < 8; k++) if (members[k] == members[i]) cnt++;
      if (cnt > bestcnt) begin
        bestcnt = cnt;
        best = i;
      end
    end
    res.solution = members[best];
    if (bestcnt * 4 >= 24) begin
      res.status = StatusConverged;
    end else if (gen_count >= gen_limit) begin
      res.status = StatusLimit;
    end else begin
      maxe = 0;
      total = 0;
      for (int i = 0; i < 8; i++) begin
        e[i] = qubo_energy(members[i]);
        if (e[i] > maxe) maxe = e[i];
      end
      for (int i = 0; i < 8; i++) begin
        total += maxe - e[i] + 1;
        cum[i] = total;
      end
      for (int i = 0; i < 8; i++) begin
        w = (i < 4) ? r.sel_lo : r.sel_hi;
        d = w[63-16*(i%4) -: 16];
        pick = 7;
        for (int j = 7; j >= 0; j--) if (d * total <= 65535 * cum[j]) pick = j;
        nxt[i] = members[pick];
      end
      for (int p = 0; p < 4; p++) begin
        a = nxt[2*p];
        b = nxt[2*p+1];
        if (r.xo_draws[63-16*p -: 16] <= xo_thresh) begin
          m = 8'hFF >> r.xo_points[11-3*p -: 3];
          nxt[2*p]   = (a & ~m) | (b & m);
          nxt[2*p+1] = (b & ~m) | (a & m);
        end
      end
      for (int i = 0; i < 8; i++) members[i] = nxt[i] ^ r.mut_mask[63-8*i -: 8];
      gen_count = gen_count + 16'd1;
      res.status = StatusEvolved;
    end
    res.generation = gen_count;
    for (int i = 0; i < 8; i++) res.pop[63-8*i -: 8] = members[i];
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [63:0] val);
    while (pending_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgInitPop:  seed_pop  = val;
      CfgMaxGen:   gen_limit = val[15:0];
      CfgXoverThr: xo_thresh = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_gen(input gen_row_t r);
    gen_result_t res;
    if (!calm && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    restart_i           <= r.restart;
    select_draws_low_i  <= r.sel_lo;
    select_draws_high_i <= r.sel_hi;
    crossover_draws_i   <= r.xo_draws;
    crossover_points_i  <= r.xo_points;
    mutation_mask_i     <= r.mut_mask;
    do @(posedge clk_i); while (!in_ready_o);
    predict_generation(r, res);
    pending_q.push_back(r.typed ? r.want : res);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic gen_row_t rand_row(input bit rs);
    gen_row_t r;
    r.restart   = rs;
    r.sel_lo    = rand64();
    r.sel_hi    = rand64();
    r.xo_draws  = rand64();
    r.xo_points = 12'($urandom_range(4095));
    case ($urandom_range(9))
      0:       r.mut_mask = '0;
      1, 2:    r.mut_mask = rand64();
      default: r.mut_mask = rand64() & rand64() & rand64() & rand64();
    endcase
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= calm || $urandom_range(99) >= 31;
  end

  always @(posedge clk_i) begin
    gen_result_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result status=%0d", status_o);
        failed = 1'b1;
      end else begin
        w = pending_q.pop_front();
        if (status_o !== w.status) begin
          $error("status: expected %0d, got %0d", w.status, status_o);
          failed = 1'b1;
        end
        if (solution_o !== w.solution) begin
          $error("solution: expected %h, got %h", w.solution, solution_o);
          failed = 1'b1;
        end
        if (generation_o !== w.generation) begin
          $error("generation: expected %0d, got %0d", w.generation, generation_o);
          failed = 1'b1;
        end
        if (population_out_o !== w.pop) begin
          $error("population_out: expected %h, got %h", w.pop, population_out_o);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    int phase_len;
    logic [15:0] lim;
    logic [15:0] thr;
    logic [63:0] init;
    failed = 1'b0;
    calm = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgInitPop;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    restart_i = 1'b0;
    select_draws_low_i = '0;
    select_draws_high_i = '0;
    crossover_draws_i = '0;
    crossover_points_i = '0;
    mutation_mask_i = '0;
    out_ready_i = 1'b0;
    for (int i = 0; i < 8; i++) members[i] = '0;
    gen_count = '0;
    seed_pop = '0;
    gen_limit = 16'd300;
    xo_thresh = 16'd49151;

    // directed rows
    rows[0] = '{1'b0, '0, '0, '0, '0, '0, 1'b1, '{StatusConverged, 8'h00, 16'd0, '0}};
    rows[1] = '{1'b1, '0, '0, '0, '0, '0, 1'b1, '{StatusConverged, 8'h00, 16'd0, '0}};
    rows[2] = '{1'b1, '0, '0, '0, 12'h000, '0, 1'b0, '0};
    rows[3] = '{1'b0, '0, '0, '0, '0, '0, 1'b1,
                '{StatusConverged, 8'h01, 16'd1, 64'h0101010101010101}};
    rows[4] = '{1'b1, '1, '1, '1, 12'hFFF, '1, 1'b0, '0};
    rows[5] = '{1'b0, 64'h8000_4000_2000_1000, 64'hFFFE_0001_7FFF_C000,
                64'h0000_FFFF_8000_7FFF, 12'h000, 64'h8000_0000_0000_0001, 1'b0, '0};
    rows[6] = '{1'b0, 64'h1234_5678_9ABC_DEF0, 64'h0F0F_F0F0_3333_CCCC,
                64'h0000_0000_0000_0000, 12'h9AC, 64'h0000_0100_0000_0000, 1'b0, '0};
    rows[7] = '{1'b0, 64'hFFFF_0000_FFFF_0000, 64'h0000_FFFF_0000_FFFF,
                '0, 12'h5A5, 64'h0000_0000_0080_0000, 1'b0, '0};
    rows[8] = '{1'b0, '0, '1, '0, 12'h249, '0, 1'b0, '0};
    rows[9] = '{1'b1, '1, '0, '1, 12'hB6D, 64'hAAAA_5555_AAAA_5555, 1'b0, '0};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 2; i++) send_gen(rows[i]);
    in_valid_i <= 1'b0;
    write_reg(CfgInitPop, 64'h0123_4567_89AB_CDEF);
    write_reg(CfgMaxGen, 64'd3);
    write_reg(CfgXoverThr, 64'hFFFF);
    for (int i = 2; i < 10; i++) send_gen(rows[i]);
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < 11; ph++) begin
      calm = (ph == 5);
      case (ph % 4)
        0: lim = 16'd1;
        1: lim = 16'd65535;
        default: lim = 16'($urandom_range(3, 60));
      endcase
      case (ph % 3)
        0: thr = 16'd0;
        1: thr = 16'd65535;
        default: thr = 16'($urandom_range(65535));
      endcase
      if (ph == 0) init = '1;
      else if (ph == 1) init = '0;
      else init = rand64();
      write_reg(CfgInitPop, init);
      write_reg(CfgMaxGen, {48'd0, lim});
      write_reg(CfgXoverThr, {48'd0, thr});
      phase_len = 50;
      for (int k = 0; k < phase_len; k++)
        send_gen(rand_row(k == 0 || $urandom_range(99) < 3));
      in_valid_i <= 1'b0;
    end
    calm = 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (!failed && pending_q.size() == 0) begin
      $display("genetic_qubo_generation regression: pass");
    end else begin
      $display("genetic_qubo_generation regression: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/gqg_pkg.sv
hdl/gqg_energy.sv
hdl/genetic_qubo_generation.sv
sim/genetic_qubo_generation_tb.sv
